// File: rtl/cfhp_pkg.sv
// ============================================================================
// cfhp_pkg
// Shared types and constants for the colon fragment header parser.
// ============================================================================
`default_nettype none

package cfhp_pkg;

    // default configuration
    localparam int HEADER_LIMIT_DEF = 100;
    localparam int MAX_PAYLOAD_DEF  = 1024;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int SIZE_W  = 11;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 56;

    // separator character and saturation ceiling of the count fields
    localparam logic [BYTE_W-1:0]  SEP_CHAR  = 8'h3A;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_NAME    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    // header field being parsed
    typedef enum logic [2:0] {
        FIELD_TOTAL   = 3'd0,
        FIELD_FRAG    = 3'd1,
        FIELD_SIZE    = 3'd2,
        FIELD_NAME    = 3'd3,
        FIELD_PAYLOAD = 3'd4
    } field_t;

    // one result item
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    out_byte;
        logic [COUNT_W-1:0]   total_frags;
        logic [COUNT_W-1:0]   frag_number;
        logic [SIZE_W-1:0]    payload_size;
        logic                 final_fragment;
        logic                 last;
    } result_t;

    // decimal accumulate: acc * 10 + digit, clamped at cap
    function automatic logic [COUNT_W-1:0] sat_accum(
        input logic [COUNT_W-1:0] acc,
        input logic [3:0]         digit,
        input logic [COUNT_W-1:0] cap
    );
        logic [COUNT_W+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{COUNT_W{1'b0}}, digit};
        return (v > {4'd0, cap}) ? cap : v[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/cfhp_parser.sv
// ============================================================================
// cfhp_parser
// Parse state and single-pass result logic; state advances once per request.
// ============================================================================
`default_nettype none

module cfhp_parser #(
    parameter int HEADER_LIMIT = cfhp_pkg::HEADER_LIMIT_DEF,
    parameter int MAX_PAYLOAD  = cfhp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire logic                        first_byte,
    input  wire logic [cfhp_pkg::BYTE_W-1:0] byte_value,
    output logic                             res_valid,
    output cfhp_pkg::result_t                res
);

    import cfhp_pkg::*;

    localparam int POS_W = $clog2(HEADER_LIMIT);
    localparam logic [POS_W-1:0]   POS_LAST = POS_W'(HEADER_LIMIT - 1);
    localparam logic [COUNT_W-1:0] SIZE_CAP = COUNT_W'(MAX_PAYLOAD);

    field_t             field_reg,  field_next;
    logic [COUNT_W-1:0] total_reg,  total_next;
    logic [COUNT_W-1:0] frag_reg,   frag_next;
    logic [SIZE_W-1:0]  size_reg,   size_next;
    logic               stop_reg,   stop_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [SIZE_W-1:0]  remain_reg, remain_next;
    logic               done_reg,   done_next;

    // state seen by this byte, after a possible restart
    field_t             field_cur;
    logic [COUNT_W-1:0] total_cur;
    logic [COUNT_W-1:0] frag_cur;
    logic [SIZE_W-1:0]  size_cur;
    logic               stop_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [SIZE_W-1:0]  remain_cur;
    logic               done_cur;
    logic [SIZE_W-1:0]  remain_dec;
    logic               is_digit;
    logic [COUNT_W-1:0] size_acc;

    // restart on the first byte of a datagram
    always_comb
    begin
        if (first_byte)
        begin
            field_cur  = FIELD_TOTAL;
            total_cur  = '0;
            frag_cur   = '0;
            size_cur   = '0;
            stop_cur   = 1'b0;
            pos_cur    = '0;
            remain_cur = '0;
            done_cur   = 1'b0;
        end
        else
        begin
            field_cur  = field_reg;
            total_cur  = total_reg;
            frag_cur   = frag_reg;
            size_cur   = size_reg;
            stop_cur   = stop_reg;
            pos_cur    = pos_reg;
            remain_cur = remain_reg;
            done_cur   = done_reg;
        end
    end

    assign is_digit   = byte_value inside {[8'h30:8'h39]};
    assign remain_dec = (remain_cur != '0) ? remain_cur - 1'b1 : remain_cur;
    assign size_acc   = sat_accum({{(COUNT_W-SIZE_W){1'b0}}, size_cur},
                                  byte_value[3:0], SIZE_CAP);

    // next state and result for one byte
    always_comb
    begin
        field_next  = field_cur;
        total_next  = total_cur;
        frag_next   = frag_cur;
        size_next   = size_cur;
        stop_next   = stop_cur;
        pos_next    = pos_cur;
        remain_next = remain_cur;
        done_next   = done_cur;
        res_valid   = 1'b0;
        res         = '0;

        if (done_cur)
        begin
            // idle byte between datagrams
        end
        else if (field_cur == FIELD_PAYLOAD)
        begin
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.out_byte  = byte_value;
            remain_next   = remain_dec;
            if (remain_dec == '0)
            begin
                res.last  = 1'b1;
                done_next = 1'b1;
            end
        end
        else if (byte_value == SEP_CHAR)
        begin
            stop_next = 1'b0;
            if (pos_cur < POS_LAST)
                pos_next = pos_cur + 1'b1;
            case (field_cur)
                FIELD_TOTAL: field_next = FIELD_FRAG;
                FIELD_FRAG:  field_next = FIELD_SIZE;
                FIELD_SIZE:  field_next = FIELD_NAME;
                default:
                begin
                    // fourth separator closes the header
                    field_next         = FIELD_PAYLOAD;
                    res_valid          = 1'b1;
                    res.kind           = KIND_HEADER;
                    res.total_frags    = total_cur;
                    res.frag_number    = frag_cur;
                    res.payload_size   = size_cur;
                    res.final_fragment = (total_cur == frag_cur);
                    remain_next        = size_cur;
                    if (size_cur == '0)
                    begin
                        res.last  = 1'b1;
                        done_next = 1'b1;
                    end
                end
            endcase
        end
        else if (pos_cur >= POS_LAST)
        begin
            // header too long
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.last  = 1'b1;
            done_next = 1'b1;
        end
        else
        begin
            pos_next = pos_cur + 1'b1;
            if (field_cur == FIELD_NAME)
            begin
                res_valid    = 1'b1;
                res.kind     = KIND_NAME;
                res.out_byte = byte_value;
            end
            else if (!stop_cur && is_digit)
            begin
                case (field_cur)
                    FIELD_TOTAL: total_next = sat_accum(total_cur, byte_value[3:0], COUNT_SAT);
                    FIELD_FRAG:  frag_next  = sat_accum(frag_cur, byte_value[3:0], COUNT_SAT);
                    default:     size_next  = size_acc[SIZE_W-1:0];
                endcase
            end
            else
            begin
                stop_next = 1'b1;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= FIELD_TOTAL;
            total_reg  <= '0;
            frag_reg   <= '0;
            size_reg   <= '0;
            stop_reg   <= 1'b0;
            pos_reg    <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b1;
        end
        else if (item_valid)
        begin
            field_reg  <= field_next;
            total_reg  <= total_next;
            frag_reg   <= frag_next;
            size_reg   <= size_next;
            stop_reg   <= stop_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    // an error result carries nothing but its kind and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_ERROR) |->
        (res.last && res.out_byte == '0 && res.payload_size == '0))
        else $error("error result with payload fields set");

    // header size never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_HEADER) |->
        ({{(COUNT_W-SIZE_W){1'b0}}, res.payload_size} <= SIZE_CAP))
        else $error("payload size above capacity");

    // while payload is open there are bytes left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        (field_reg == FIELD_PAYLOAD && !done_reg) |-> (remain_reg != '0))
        else $error("payload open with no bytes remaining");

    // header position stays within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("header position beyond limit");

endmodule

`default_nettype wire

// File: rtl/colon_fragment_header_parser_top.sv
// ============================================================================
// colon_fragment_header_parser_top
// Byte stream parser for total:frag:size:name:data datagrams.
// ============================================================================
// input request to result passes through the input register, then the result register
// throughput: one byte per cycle unless stalled; each byte gives zero or one result
// the parse step between the two registers is a single combinational pass
// reset: asynchronous, active low; parser waits for a first-byte marker
`default_nettype none

module colon_fragment_header_parser_top #(
    parameter int HEADER_LIMIT = cfhp_pkg::HEADER_LIMIT_DEF,
    parameter int MAX_PAYLOAD  = cfhp_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [cfhp_pkg::BYTE_W-1:0]  s_tdata,   // byte_value
    input  wire logic                         s_tuser,   // first_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [cfhp_pkg::TDATA_W-1:0]      m_tdata,   // out_byte, total_frags,
                                                         // frag_number, payload_size,
                                                         // final_fragment, zero pad
    output logic [cfhp_pkg::KIND_W-1:0]       m_tuser,   // kind
    output logic                              m_tlast    // last
);

    import cfhp_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_first_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              advance;
    logic              res_valid;
    result_t           res;

    // input request moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    cfhp_parser #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .first_byte (in_first_reg),
        .byte_value (in_byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register
    always_comb
    begin
        if (advance)
            out_valid_next = res_valid;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'd0, out_reg.final_fragment, out_reg.payload_size,
                       out_reg.frag_number, out_reg.total_frags, out_reg.out_byte};

    // an empty input stage always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // a pending result blocked downstream holds the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // a stalled result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
